/* rtl/ftrb_pkg.sv */
// ----------------------------------------------------------------------------
// ftrb_pkg
// Shared types and codes for the freezable trace ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ftrb_pkg;

    localparam int OP_W    = 3;
    localparam int INDEX_W = 10;
    localparam int CAP_W   = 11;
    localparam int COUNT_W = 11;
    localparam int DROP_W  = 32;
    localparam int WORD_W  = 64;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_READ   = 3'd1;
    localparam logic [OP_W-1:0] OP_FREEZE = 3'd2;
    localparam logic [OP_W-1:0] OP_RESUME = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    typedef enum logic [2:0] {
        CLS_PUSH,
        CLS_READ,
        CLS_FREEZE,
        CLS_RESUME,
        CLS_CLEAR,
        CLS_NOP
    } item_class_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_MEM,
        ST_RESP
    } back_state_t;

    // head of the front queue as seen by the back end
    typedef struct packed {
        logic                  valid;
        item_class_t           cls;
        logic [INDEX_W-1:0]    read_index;
    } queue_head_t;

    function automatic item_class_t classify(input logic [OP_W-1:0] op);
        item_class_t cls;
        begin
            unique case (op)
                OP_PUSH:   cls = CLS_PUSH;
                OP_READ:   cls = CLS_READ;
                OP_FREEZE: cls = CLS_FREEZE;
                OP_RESUME: cls = CLS_RESUME;
                OP_CLEAR:  cls = CLS_CLEAR;
                default:   cls = CLS_NOP;
            endcase
            return cls;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/freezable_trace_ring_buffer.sv */
// ----------------------------------------------------------------------------
// freezable_trace_ring_buffer
// Overwriting trace buffer with freeze, drop count and chronological reads.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  item      | item_valid / item_ready    | op, entry_word, read_index
//  result    | result_valid / result_ready| ok, read_data, entry_count,
//            |                            | head_position, is_full, is_active,
//            |                            | dropped_count
//  config    | cfg_write_en               | cfg_write_data (capacity)
//
//  A transaction is registered in the two-deep front queue, then the back end
//  runs it: push, freeze, resume, clear and bad ops complete from the idle
//  state, reads go through the slot map, then a registered RAM read. A wrapped
//  read whose head + index reaches twice the capacity first runs a bit-serial
//  remainder over SW = max(clog2(DEPTH), 10) + 1 bits. One transaction in the
//  back end at a time. Reset is immediate, no clearing pass; stalls on
//  result_ready hold the back end only once the result register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module freezable_trace_ring_buffer #(
    parameter int DEPTH       = 1024,
    parameter int ENTRY_WIDTH = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [ftrb_pkg::CAP_W-1:0]     cfg_write_data,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic [ftrb_pkg::OP_W-1:0]      op,
    input  wire logic [ftrb_pkg::WORD_W-1:0]    entry_word,
    input  wire logic [ftrb_pkg::INDEX_W-1:0]   read_index,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic                                ok,
    output logic [ftrb_pkg::WORD_W-1:0]         read_data,
    output logic [ftrb_pkg::COUNT_W-1:0]        entry_count,
    output logic [ftrb_pkg::INDEX_W-1:0]        head_position,
    output logic                                is_full,
    output logic                                is_active,
    output logic [ftrb_pkg::DROP_W-1:0]         dropped_count
);
    import ftrb_pkg::*;

    queue_head_t            q_head;
    logic [ENTRY_WIDTH-1:0] q_word;
    logic                   pop;

    ftrb_front #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .op         (op),
        .entry_word (entry_word),
        .read_index (read_index),
        .q_head     (q_head),
        .q_word     (q_word),
        .pop        (pop)
    );

    ftrb_back #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .q_head         (q_head),
        .q_word         (q_word),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .ok             (ok),
        .read_data      (read_data),
        .entry_count    (entry_count),
        .head_position  (head_position),
        .is_full        (is_full),
        .is_active      (is_active),
        .dropped_count  (dropped_count)
    );

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_head.valid)
        else $error("queue popped while empty");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !ok) |-> (read_data == '0))
        else $error("failed transaction carries read data");

    a_count_tracks_head: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !is_full) |-> (entry_count[INDEX_W-1:0] == head_position))
        else $error("entry count differs from head before wrap");
`endif

endmodule

`default_nettype wire

/* rtl/ftrb_front.sv */
// ----------------------------------------------------------------------------
// ftrb_front
// Accepts input transactions, decodes the op and queues them (two deep).
// ----------------------------------------------------------------------------
`default_nettype none

module ftrb_front #(
    parameter int ENTRY_WIDTH = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic [ftrb_pkg::OP_W-1:0]      op,
    input  wire logic [ftrb_pkg::WORD_W-1:0]    entry_word,
    input  wire logic [ftrb_pkg::INDEX_W-1:0]   read_index,
    output ftrb_pkg::queue_head_t               q_head,
    output logic [ENTRY_WIDTH-1:0]              q_word,
    input  wire logic                           pop
);
    import ftrb_pkg::*;

    item_class_t              cls_mem  [2];
    logic [ENTRY_WIDTH-1:0]   word_mem [2];
    logic [INDEX_W-1:0]       idx_mem  [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign item_ready = (count_reg != 2'd2);
    assign push       = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cls_mem[wr_ptr_reg]  <= classify(op);
            word_mem[wr_ptr_reg] <= entry_word[ENTRY_WIDTH-1:0];
            idx_mem[wr_ptr_reg]  <= read_index;
        end
    end

    always_comb
    begin
        q_head.valid      = (count_reg != 2'd0);
        q_head.cls        = cls_mem[rd_ptr_reg];
        q_head.read_index = idx_mem[rd_ptr_reg];
        q_word            = word_mem[rd_ptr_reg];
    end

endmodule

`default_nettype wire

/* rtl/ftrb_back.sv */
// ----------------------------------------------------------------------------
// ftrb_back
// Executes queued transactions: ring state, entry memory, index mapping,
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftrb_back #(
    parameter int DEPTH       = 1024,
    parameter int ENTRY_WIDTH = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [ftrb_pkg::CAP_W-1:0]     cfg_write_data,
    input  wire ftrb_pkg::queue_head_t          q_head,
    input  wire logic [ENTRY_WIDTH-1:0]         q_word,
    output logic                                pop,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic                                ok,
    output logic [ftrb_pkg::WORD_W-1:0]         read_data,
    output logic [ftrb_pkg::COUNT_W-1:0]        entry_count,
    output logic [ftrb_pkg::INDEX_W-1:0]        head_position,
    output logic                                is_full,
    output logic                                is_active,
    output logic [ftrb_pkg::DROP_W-1:0]         dropped_count
);
    import ftrb_pkg::*;

    localparam int HW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int SW        = ((HW > INDEX_W) ? HW : INDEX_W) + 1;
    localparam int NW        = $clog2(SW + 1);
    localparam int RESET_CAP = (DEPTH < 1024) ? DEPTH : 1024;

    logic [ENTRY_WIDTH-1:0] store_mem [DEPTH];

    back_state_t       state_reg, state_next;
    logic [HW-1:0]     head_reg, head_next;
    logic              wrapped_reg, wrapped_next;
    logic              capturing_reg, capturing_next;
    logic [DROP_W-1:0] drop_reg, drop_next;
    logic [CW-1:0]     cap_reg;
    logic [SW-1:0]     mod_num_reg, mod_num_next;
    logic [CW-1:0]     mod_rem_reg, mod_rem_next;
    logic [NW-1:0]     mod_cnt_reg, mod_cnt_next;
    logic              read_ok_reg, read_ok_next;
    logic [ENTRY_WIDTH-1:0] rd_data_reg;

    logic                   out_valid_reg;
    logic                   ok_reg;
    logic [WORD_W-1:0]      data_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [INDEX_W-1:0]     headpos_reg;
    logic                   full_reg;
    logic                   active_reg;
    logic [DROP_W-1:0]      dropped_reg;

    logic                   out_free;
    logic                   out_load;
    logic                   res_ok;
    logic [ENTRY_WIDTH-1:0] res_data;
    logic                   mem_we;
    logic                   mem_re;
    logic [HW-1:0]          mem_raddr;

    logic [31:0]   cap32, head32, idx32, held32, sum32, inc32, trial32;
    logic [31:0]   held_next32, head_next32;
    logic [SW-1:0] sum;
    logic          idx_ok, fast_ok;
    logic [HW-1:0] fast_slot;
    logic [CW:0]   trial;

    assign out_free = !out_valid_reg || result_ready;

    // index mapping, shared terms
    always_comb
    begin
        cap32   = 32'(cap_reg);
        head32  = 32'(head_reg);
        idx32   = 32'(q_head.read_index);
        held32  = wrapped_reg ? cap32 : head32;
        idx_ok  = idx32 < held32;
        sum     = SW'(head_reg) + SW'(q_head.read_index);
        sum32   = 32'(sum);
        fast_ok = !wrapped_reg || (sum32 < (cap32 << 1));
        inc32   = head32 + 32'd1;
        if (!wrapped_reg)
            fast_slot = HW'(q_head.read_index);
        else if (sum32 >= cap32)
            fast_slot = HW'(sum32 - cap32);
        else
            fast_slot = HW'(sum);
        // one restoring step of the remainder
        trial   = {mod_rem_reg, mod_num_reg[SW-1]};
        trial32 = 32'(trial);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_head.valid && q_head.cls == CLS_READ)
                begin
                    if (!idx_ok || fast_ok)
                        state_next = ST_RESP;
                    else
                        state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_cnt_reg == NW'(1))
                    state_next = ST_MEM;
            end
            ST_MEM:  state_next = ST_RESP;
            ST_RESP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        wrapped_next   = wrapped_reg;
        capturing_next = capturing_reg;
        drop_next      = drop_reg;
        mod_num_next   = mod_num_reg;
        mod_rem_next   = mod_rem_reg;
        mod_cnt_next   = mod_cnt_reg;
        read_ok_next   = read_ok_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = HW'(mod_rem_reg);
        out_load       = 1'b0;
        res_ok         = 1'b0;
        res_data       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_head.valid && q_head.cls == CLS_READ)
                begin
                    pop          = 1'b1;
                    read_ok_next = idx_ok;
                    if (idx_ok && fast_ok)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = fast_slot;
                    end
                    else if (idx_ok)
                    begin
                        mod_num_next = sum;
                        mod_rem_next = '0;
                        mod_cnt_next = NW'(SW);
                    end
                end
                else if (q_head.valid && out_free)
                begin
                    pop      = 1'b1;
                    out_load = 1'b1;
                    unique case (q_head.cls)
                        CLS_PUSH:
                        begin
                            if (capturing_reg)
                            begin
                                mem_we = 1'b1;
                                res_ok = 1'b1;
                                if (inc32 >= cap32)
                                begin
                                    head_next    = '0;
                                    wrapped_next = 1'b1;
                                end
                                else
                                    head_next = HW'(inc32);
                            end
                            else
                                drop_next = drop_reg + DROP_W'(1);
                        end
                        CLS_FREEZE:
                        begin
                            capturing_next = 1'b0;
                            res_ok         = 1'b1;
                        end
                        CLS_RESUME:
                        begin
                            capturing_next = 1'b1;
                            res_ok         = 1'b1;
                        end
                        CLS_CLEAR:
                        begin
                            head_next      = '0;
                            wrapped_next   = 1'b0;
                            capturing_next = 1'b1;
                            drop_next      = '0;
                            res_ok         = 1'b1;
                        end
                        CLS_READ, CLS_NOP:
                        begin
                            res_ok = 1'b0;
                        end
                        default:
                        begin
                            res_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                mod_num_next = mod_num_reg << 1;
                mod_cnt_next = mod_cnt_reg - NW'(1);
                if (trial32 >= cap32)
                    mod_rem_next = CW'(trial32 - cap32);
                else
                    mod_rem_next = CW'(trial);
            end
            ST_MEM:
            begin
                mem_re = 1'b1;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    res_ok   = read_ok_reg;
                    res_data = read_ok_reg ? rd_data_reg : '0;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // status after the transaction
    always_comb
    begin
        head_next32 = 32'(head_next);
        held_next32 = wrapped_next ? cap32 : head_next32;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            wrapped_reg   <= 1'b0;
            capturing_reg <= 1'b1;
            drop_reg      <= '0;
            cap_reg       <= CW'(RESET_CAP);
            mod_cnt_reg   <= '0;
            read_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            wrapped_reg   <= wrapped_next;
            capturing_reg <= capturing_next;
            drop_reg      <= drop_next;
            mod_cnt_reg   <= mod_cnt_next;
            read_ok_reg   <= read_ok_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            // zero acts as one, anything above the depth as the depth
            if (cfg_write_en)
            begin
                if (cfg_write_data == '0)
                    cap_reg <= CW'(1);
                else if (32'(cfg_write_data) > 32'(DEPTH))
                    cap_reg <= CW'(DEPTH);
                else
                    cap_reg <= CW'(cfg_write_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mod_num_reg <= mod_num_next;
        mod_rem_reg <= mod_rem_next;
        if (out_load)
        begin
            ok_reg      <= res_ok;
            data_reg    <= WORD_W'(res_data);
            count_reg   <= held_next32[COUNT_W-1:0];
            headpos_reg <= head_next32[INDEX_W-1:0];
            full_reg    <= wrapped_next;
            active_reg  <= capturing_next;
            dropped_reg <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[head_reg] <= q_word;
        if (mem_re)
            rd_data_reg <= store_mem[mem_raddr];
    end

    assign result_valid  = out_valid_reg;
    assign ok            = ok_reg;
    assign read_data     = data_reg;
    assign entry_count   = count_reg;
    assign head_position = headpos_reg;
    assign is_full       = full_reg;
    assign is_active     = active_reg;
    assign dropped_count = dropped_reg;

endmodule

`default_nettype wire
